// File: src/ahdlc_pkg.sv
// ----------------------------------------------------------------------------
// ahdlc_pkg
// shared constants, codes and the fcs-16 byte update for the hdlc receiver
// ----------------------------------------------------------------------------
package ahdlc_pkg;

    localparam logic [7:0]  FLAG_BYTE = 8'h7E;
    localparam logic [7:0]  ESC_BYTE  = 8'h7D;
    localparam logic [7:0]  ESC_XOR   = 8'h20;
    localparam logic [7:0]  ADDR_SCAN = 8'h00;
    localparam logic [15:0] FCS_INIT  = 16'hFFFF;
    localparam logic [15:0] FCS_GOOD  = 16'hF0B8;
    localparam logic [15:0] FCS_POLY  = 16'h8408;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCANNING_MODE = 8'd0,
        CFG_DEVICE_COUNT  = 8'd1
    } t_cfg_index;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_REPORT  = 1'b1
    } t_result_kind;

    typedef enum logic [1:0] {
        STAT_GOOD  = 2'd0,
        STAT_BAD   = 2'd1,
        STAT_SHORT = 2'd2
    } t_frame_status;

    typedef enum logic [1:0] {
        ROUTE_SCAN    = 2'd0,
        ROUTE_DEVICE  = 2'd1,
        ROUTE_DISCARD = 2'd2
    } t_route;

    // reflected crc over one byte, lsb first
    function automatic logic [15:0] fcs16_update(input logic [15:0] acc,
                                                 input logic [7:0]  data);
        logic [15:0] c;
        c = acc ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ FCS_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// File: src/async_hdlc_frame_receiver.sv
// ----------------------------------------------------------------------------
// async_hdlc_frame_receiver
// an accepted byte's result word is registered and appears at the output in the next cycle
// throughput: one byte per cycle while the output is not held, set by the single fcs/de-stuff stage
// the output register frees up in the same cycle its word is taken
// reset (synchronous, active low) clears frame state and config to defaults
// ----------------------------------------------------------------------------
module async_hdlc_frame_receiver
    import ahdlc_pkg::*;
#(
    parameter int MAX_FRAME_LEN = 1024,
    localparam int LEN_W = $clog2(MAX_FRAME_LEN + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,

    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_rx_byte,

    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_result_kind,
    output logic [7:0]            o_payload_byte,
    output logic [1:0]            o_frame_status,
    output logic [1:0]            o_route,
    output logic [7:0]            o_frame_address,
    output logic [7:0]            o_frame_control,
    output logic [LEN_W-1:0]      o_frame_length
);

    logic             r_scanning_mode;
    logic [7:0]       r_device_count;

    logic             r_in_frame,   n_in_frame;
    logic             r_esc_pend,   n_esc_pend;
    logic             r_raw_seen,   n_raw_seen;
    logic [15:0]      r_fcs,        n_fcs;
    logic [LEN_W-1:0] r_count,      n_count;
    logic [7:0]       r_addr,       n_addr;
    logic [7:0]       r_ctrl,       n_ctrl;

    logic             r_out_valid;
    logic             r_kind;
    logic [7:0]       r_payload;
    logic [1:0]       r_status;
    logic [1:0]       r_route;
    logic [7:0]       r_faddr;
    logic [7:0]       r_fctrl;
    logic [LEN_W-1:0] r_flen;

    logic             res_valid;
    t_result_kind     res_kind;
    logic [7:0]       res_payload;
    t_frame_status    res_status;
    t_route           res_route;
    logic [7:0]       res_addr;
    logic [7:0]       res_ctrl;
    logic [LEN_W-1:0] res_len;
    logic [7:0]       data_byte;
    logic             in_acc;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scanning_mode <= 1'b0;
            r_device_count  <= 8'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SCANNING_MODE: r_scanning_mode <= i_cfg_data[0];
                CFG_DEVICE_COUNT:  r_device_count  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // per-byte deframing
    always_comb begin
        n_in_frame  = r_in_frame;
        n_esc_pend  = r_esc_pend;
        n_raw_seen  = r_raw_seen;
        n_fcs       = r_fcs;
        n_count     = r_count;
        n_addr      = r_addr;
        n_ctrl      = r_ctrl;
        res_valid   = 1'b0;
        res_kind    = KIND_PAYLOAD;
        res_payload = 8'd0;
        res_status  = STAT_GOOD;
        res_route   = ROUTE_SCAN;
        res_addr    = 8'd0;
        res_ctrl    = 8'd0;
        res_len     = '0;
        data_byte   = r_esc_pend ? (i_rx_byte ^ ESC_XOR) : i_rx_byte;

        if (!r_in_frame) begin
            if (i_rx_byte == FLAG_BYTE) begin
                n_in_frame = 1'b1;
                n_esc_pend = 1'b0;
                n_raw_seen = 1'b0;
                n_fcs      = FCS_INIT;
                n_count    = '0;
                n_addr     = 8'd0;
                n_ctrl     = 8'd0;
            end
        end else if (i_rx_byte != FLAG_BYTE) begin
            n_raw_seen = 1'b1;
            if (!r_esc_pend && i_rx_byte == ESC_BYTE) begin
                n_esc_pend = 1'b1;
            end else begin
                n_esc_pend  = 1'b0;
                n_fcs       = fcs16_update(r_fcs, data_byte);
                if (r_count == '0) begin
                    n_addr = data_byte;
                end else if (r_count == LEN_W'(1)) begin
                    n_ctrl = data_byte;
                end
                if (r_count < LEN_W'(MAX_FRAME_LEN)) begin
                    n_count = r_count + LEN_W'(1);
                end
                res_valid   = 1'b1;
                res_payload = data_byte;
            end
        end else if (r_raw_seen) begin
            res_valid = 1'b1;
            res_kind  = KIND_REPORT;
            if (r_fcs != FCS_GOOD) begin
                res_status = STAT_BAD;
            end else if (r_count < LEN_W'(2)) begin
                res_status = STAT_SHORT;
            end else begin
                res_status = STAT_GOOD;
            end
            res_route = ROUTE_DISCARD;
            if (res_status == STAT_GOOD) begin
                if (r_scanning_mode && r_ctrl[1:0] == 2'b11 && r_addr == ADDR_SCAN) begin
                    res_route = ROUTE_SCAN;
                end else if (r_addr != 8'd0 && r_addr <= r_device_count) begin
                    res_route = ROUTE_DEVICE;
                end
            end
            res_addr   = r_addr;
            res_ctrl   = r_ctrl;
            res_len    = r_count;
            n_in_frame = 1'b0;
            n_esc_pend = 1'b0;
            n_raw_seen = 1'b0;
            n_fcs      = FCS_INIT;
            n_count    = '0;
            n_addr     = 8'd0;
            n_ctrl     = 8'd0;
        end
    end

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_esc_pend <= 1'b0;
            r_raw_seen <= 1'b0;
            r_fcs      <= FCS_INIT;
            r_count    <= '0;
            r_addr     <= 8'd0;
            r_ctrl     <= 8'd0;
        end else if (in_acc) begin
            r_in_frame <= n_in_frame;
            r_esc_pend <= n_esc_pend;
            r_raw_seen <= n_raw_seen;
            r_fcs      <= n_fcs;
            r_count    <= n_count;
            r_addr     <= n_addr;
            r_ctrl     <= n_ctrl;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= res_valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && res_valid) begin
            r_kind    <= res_kind;
            r_payload <= res_payload;
            r_status  <= res_status;
            r_route   <= res_route;
            r_faddr   <= res_addr;
            r_fctrl   <= res_ctrl;
            r_flen    <= res_len;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_kind   = r_kind;
    assign o_payload_byte  = r_payload;
    assign o_frame_status  = r_status;
    assign o_route         = r_route;
    assign o_frame_address = r_faddr;
    assign o_frame_control = r_fctrl;
    assign o_frame_length  = r_flen;

    a_hunt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !r_in_frame |=> !o_out_valid)
        else $error("result produced while hunting for flag");

    a_route_good_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind == KIND_REPORT && o_frame_status != STAT_GOOD
        |-> o_route == ROUTE_DISCARD)
        else $error("bad frame not discarded");

    a_report_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind == KIND_REPORT
        |-> o_payload_byte == 8'd0 && o_frame_length <= LEN_W'(MAX_FRAME_LEN))
        else $error("report word malformed");

    a_frame_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && res_kind == KIND_REPORT && res_valid |=> !r_in_frame && r_fcs == FCS_INIT)
        else $error("frame state not cleared after closing flag");

endmodule
